// ----- rtl/core/xcfp_pkg.sv -----
// Package for the XOR-checked command frame parser.
// Holds the frame constants, parse phase and status codes, and the result struct.
// No dependencies.
`default_nettype none

package xcfp_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'hAA;
   localparam logic [7:0] END_BYTE   = 8'h55;
   localparam logic [7:0] OPC_MOVE   = 8'h01;
   localparam logic [7:0] OPC_DANCE  = 8'h02;
   localparam logic [7:0] OPC_LIGHT  = 8'h03;
   localparam logic [7:0] OPC_STOP   = 8'h04;

   // Parser position within a frame
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_COMMAND = 3'd1,
      PH_DATA    = 3'd2,
      PH_CHECK   = 3'd3,
      PH_TAIL    = 3'd4
   } phase_type;

   // Frame status, checked in order: tail, checksum, command
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_CHECKSUM  = 2'd2,
      ST_BAD_TAIL  = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [7:0]         command;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } result_type;

   function automatic logic known_command(input logic [7:0] c);
      return (c == OPC_MOVE) || (c == OPC_DANCE) || (c == OPC_LIGHT) || (c == OPC_STOP);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xcfp_frame_fsm.sv -----
// Frame hunting state machine: tracks the byte position, collects command and
// data, keeps the running XOR, and forms a result at the tail byte.
// Depends on xcfp_pkg.
`default_nettype none

module xcfp_frame_fsm
   import xcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   output logic            at_tail,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  command_ff, command_in;
   logic [31:0] data_ff, data_in;
   logic [7:0]  xor_ff, xor_in;
   logic        csum_ok_ff, csum_ok_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         index_ff   <= 2'd0;
         command_ff <= 8'd0;
         data_ff    <= 32'd0;
         xor_ff     <= 8'd0;
         csum_ok_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         command_ff <= command_in;
         data_ff    <= data_in;
         xor_ff     <= xor_in;
         csum_ok_ff <= csum_ok_in;
      end
   end

   assign at_tail = (phase_ff == PH_TAIL);

   // Next state and result
   always_comb begin
      phase_in       = phase_ff;
      index_in       = index_ff;
      command_in     = command_ff;
      data_in        = data_ff;
      xor_in         = xor_ff;
      csum_ok_in     = csum_ok_ff;
      result.valid   = 1'b0;
      result.status  = ST_OK;
      result.command = command_ff;
      result.x       = data_ff[31:16];
      result.y       = data_ff[15:0];

      if (accept) begin
         unique case (phase_ff)
            PH_COMMAND: begin
               command_in = rx_byte;
               xor_in     = rx_byte;
               data_in    = 32'd0;
               index_in   = 2'd0;
               phase_in   = PH_DATA;
            end
            PH_DATA: begin
               data_in  = {data_ff[23:0], rx_byte};
               xor_in   = xor_ff ^ rx_byte;
               index_in = index_ff + 2'd1;
               if (index_ff == 2'd3) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               csum_ok_in = (rx_byte == xor_ff);
               phase_in   = PH_TAIL;
            end
            PH_TAIL: begin
               result.valid = 1'b1;
               priority if (rx_byte != END_BYTE) begin
                  result.status = ST_BAD_TAIL;
               end else if (!csum_ok_ff) begin
                  result.status = ST_CHECKSUM;
               end else if (!known_command(command_ff)) begin
                  result.status = ST_UNKNOWN;
               end else begin
                  result.status = ST_OK;
               end
               phase_in = PH_HEADER;
            end
            default: begin
               // Header hunt; unused codes behave the same
               phase_in = (rx_byte == SYNC_BYTE) ? PH_COMMAND : PH_HEADER;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/xor_checked_command_frame_parser.sv -----
// XOR-checked command frame parser, top level.
//
// Request channel: one received byte (req_rx_byte) per request, taken at a
// clock edge with req_valid high and req_stall low. The parser hunts for
// 8-byte frames: 0xAA, command, X high/low, Y high/low, XOR checksum, 0x55.
// Response channel: one response per frame, issued for the tail position
// byte whatever it holds, carrying status, command, X and Y.
// Latency: the response is valid the cycle after its tail byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the parser state and the
// running XOR are registered, and the response sits in one output register.
// When the receiver stalls, the response holds. Requests keep being taken
// unless the next byte is a tail byte while the output register is still
// occupied and stalled; then req_stall is raised until it drains.
// Reset (synchronous, active high) returns the parser to header hunt and
// empties the output register.
// Depends on xcfp_pkg and xcfp_frame_fsm.
`default_nettype none

module xor_checked_command_frame_parser
   import xcfp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_frame_status,
   output logic [7:0]              rsp_command_code,
   output logic signed [15:0]      rsp_x_value,
   output logic signed [15:0]      rsp_y_value
);

   logic               accept;
   logic               at_tail;
   logic               take;
   result_type         result;
   logic               valid_ff;
   status_type         status_ff;
   logic [7:0]         command_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;

   // Hold off only a byte that would produce a response into a full, stalled register
   assign req_stall = valid_ff && rsp_stall && at_tail;
   assign accept    = req_valid && !req_stall;
   assign take      = !valid_ff || !rsp_stall;

   xcfp_frame_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .at_tail (at_tail),
      .result  (result)
   );

   // Output register: valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= result.valid;
      end
   end

   // Output register: payload
   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         status_ff  <= result.status;
         command_ff <= result.command;
         x_ff       <= result.x;
         y_ff       <= result.y;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_command_code = command_ff;
   assign rsp_x_value      = x_ff;
   assign rsp_y_value      = y_ff;

endmodule

`default_nettype wire

// ----- rtl/core/xcfp_checker.sv -----
// Port-level checks for the frame parser, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none

module xcfp_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_frame_status,
   input wire logic [7:0]  rsp_command_code,
   input wire logic [15:0] rsp_x_value,
   input wire logic [15:0] rsp_y_value
);

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_frame_status) && $stable(rsp_command_code)
         && $stable(rsp_x_value) && $stable(rsp_y_value))
      else $error("stalled response payload changed");

   // Output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A new response only follows an accepted request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response without an accepted request");

endmodule

bind xor_checked_command_frame_parser xcfp_port_checks u_xcfp_port_checks (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_status (rsp_frame_status),
   .rsp_command_code (rsp_command_code),
   .rsp_x_value      (rsp_x_value),
   .rsp_y_value      (rsp_y_value)
);

`default_nettype wire

// ----- tb/xcfp_checker.sv -----
// Checker for the XOR-checked command frame parser: follows the request byte stream,
// keeps its own parser state and queues the frame report due at each tail position.
// Depends on xcfp_pkg for the frame constants and the status codes.
`timescale 1ns / 100ps

module xcfp_checker
   import xcfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_frame_status,
   input  logic [7:0]         rsp_command_code,
   input  logic signed [15:0] rsp_x_value,
   input  logic signed [15:0] rsp_y_value,
   output int                 fail_count,
   output int                 pending_count,
   output int                 request_count,
   output int                 response_count,
   output int                 ok_count,
   output int                 unknown_count,
   output int                 checksum_count,
   output int                 bad_tail_count
);

   typedef struct {
      status_type         status;
      logic [7:0]         command;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } frame_report_type;

   frame_report_type pending_reports[$];

   // Shadow parser state
   phase_type  frame_phase;
   logic [1:0] data_count;
   logic [7:0] frame_command;
   logic [31:0] frame_data;
   logic [7:0] frame_xor;
   logic       frame_sum_good;

   int mismatches;
   int requests_seen;
   int responses_seen;
   int status_hits [4];

   // Advance the shadow parser by one byte; queue a report at the tail position
   task automatic parse_frame_byte(input logic [7:0] b);
      frame_report_type r;
      case (frame_phase)
         PH_COMMAND: begin
            frame_command = b;
            frame_xor     = b;
            frame_data    = '0;
            data_count    = '0;
            frame_phase   = PH_DATA;
         end
         PH_DATA: begin
            frame_data = {frame_data[23:0], b};
            frame_xor  = frame_xor ^ b;
            if (data_count == 2'd3) begin
               data_count  = '0;
               frame_phase = PH_CHECK;
            end else begin
               data_count = data_count + 2'd1;
            end
         end
         PH_CHECK: begin
            frame_sum_good = (b == frame_xor);
            frame_phase    = PH_TAIL;
         end
         PH_TAIL: begin
            // Priority: tail, then checksum, then command code
            if (b != END_BYTE)
               r.status = ST_BAD_TAIL;
            else if (!frame_sum_good)
               r.status = ST_CHECKSUM;
            else if (frame_command != OPC_MOVE && frame_command != OPC_DANCE &&
                     frame_command != OPC_LIGHT && frame_command != OPC_STOP)
               r.status = ST_UNKNOWN;
            else
               r.status = ST_OK;
            r.command = frame_command;
            r.x       = frame_data[31:16];
            r.y       = frame_data[15:0];
            pending_reports = {pending_reports, r};
            frame_phase = PH_HEADER;
         end
         default: begin
            frame_phase = (b == SYNC_BYTE) ? PH_COMMAND : PH_HEADER;
         end
      endcase
   endtask

   initial begin
      mismatches     = 0;
      requests_seen  = 0;
      responses_seen = 0;
      for (int i = 0; i < 4; i++) status_hits[i] = 0;
   end

   // Responses are checked before the request of the same edge is parsed:
   // a response never leaves in the cycle its tail byte is taken.
   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         pending_reports.delete();
         frame_phase    = PH_HEADER;
         data_count     = '0;
         frame_command  = '0;
         frame_data     = '0;
         frame_xor      = '0;
         frame_sum_good = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (pending_reports.size() == 0) begin
               $error("unexpected response: status %0d command %02h x %0d y %0d",
                      rsp_frame_status, rsp_command_code, rsp_x_value, rsp_y_value);
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               status_hits[want.status]++;
               if (rsp_frame_status != want.status) begin
                  $error("frame_status: expected %0d, actual %0d",
                         want.status, rsp_frame_status);
                  mismatches++;
               end
               if (rsp_command_code != want.command) begin
                  $error("command_code: expected %02h, actual %02h",
                         want.command, rsp_command_code);
                  mismatches++;
               end
               if (rsp_x_value != want.x) begin
                  $error("x_value: expected %0d, actual %0d", want.x, rsp_x_value);
                  mismatches++;
               end
               if (rsp_y_value != want.y) begin
                  $error("y_value: expected %0d, actual %0d", want.y, rsp_y_value);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            requests_seen++;
            parse_frame_byte(req_rx_byte);
         end
      end
      fail_count     <= mismatches;
      pending_count  <= pending_reports.size();
      request_count  <= requests_seen;
      response_count <= responses_seen;
      ok_count       <= status_hits[ST_OK];
      unknown_count  <= status_hits[ST_UNKNOWN];
      checksum_count <= status_hits[ST_CHECKSUM];
      bad_tail_count <= status_hits[ST_BAD_TAIL];
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the XOR-checked command frame parser: clock, reset, byte stream
// stimulus with random idling on both channels, and the final verdict.
// Depends on xcfp_pkg, the parser RTL and xcfp_checker.
`timescale 1ns / 100ps

module tb;
   import xcfp_pkg::*;

   localparam int FRAME_BYTE_GOAL = 700;
   localparam int LONG_HOLD       = 150;
   localparam int DRAIN_CYCLES    = 16;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_frame_status;
   logic [7:0]         rsp_command_code;
   logic signed [15:0] rsp_x_value;
   logic signed [15:0] rsp_y_value;

   int fail_count;
   int pending_count;
   int request_count;
   int response_count;
   int ok_count;
   int unknown_count;
   int checksum_count;
   int bad_tail_count;

   // Idling controls for the sender and the receiver
   bit req_idling = 1'b1;
   bit rsp_idling = 1'b1;
   int holds_asked = 0;
   int holds_done  = 0;
   int frame_bytes = 0;

   always #4 clock = ~clock;

   xor_checked_command_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_command_code (rsp_command_code),
      .rsp_x_value      (rsp_x_value),
      .rsp_y_value      (rsp_y_value)
   );

   xcfp_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_command_code (rsp_command_code),
      .rsp_x_value      (rsp_x_value),
      .rsp_y_value      (rsp_y_value),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .request_count    (request_count),
      .response_count   (response_count),
      .ok_count         (ok_count),
      .unknown_count    (unknown_count),
      .checksum_count   (checksum_count),
      .bad_tail_count   (bad_tail_count)
   );

   // Offer one byte, with an optional idle burst first; returns once it is taken
   task automatic send_byte(input logic [7:0] b);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Full 8-byte frame; sum_flip corrupts the checksum when nonzero
   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] x,
                             input logic [15:0] y, input logic [7:0] sum_flip,
                             input logic [7:0] tail);
      logic [7:0] sum;
      sum = cmd ^ x[15:8] ^ x[7:0] ^ y[15:8] ^ y[7:0] ^ sum_flip;
      send_byte(SYNC_BYTE);
      send_byte(cmd);
      send_byte(x[15:8]);
      send_byte(x[7:0]);
      send_byte(y[15:8]);
      send_byte(y[7:0]);
      send_byte(sum);
      send_byte(tail);
      frame_bytes += 8;
   endtask

   // Data words lean toward the signed extremes, zero and minus one
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 9))
         0, 1:    return OPC_MOVE;
         2, 3:    return OPC_DANCE;
         4, 5:    return OPC_LIGHT;
         6, 7:    return OPC_STOP;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_tail();
      case ($urandom_range(0, 11))
         0:       return SYNC_BYTE;
         1:       return 8'($urandom_range(0, 255));
         default: return END_BYTE;
      endcase
   endfunction

   // Receiver: random stall bursts, plus a long hold-off when the sender asks
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int frame_no;
      int noise_len;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes on a good move, unknown command with header and tail
      // bytes as data, then a light frame with bad checksum and a header byte at
      // the tail position followed by a byte that must not be a command.
      send_frame(OPC_MOVE, 16'h7FFF, 16'h8000, 8'h00, END_BYTE);
      send_byte(8'hFF);
      send_frame(8'hFF, {SYNC_BYTE, END_BYTE}, 16'h00FF, 8'h00, END_BYTE);
      send_frame(OPC_LIGHT, 16'h0000, 16'h0001, 8'hFF, SYNC_BYTE);
      send_byte(OPC_MOVE);

      // Random frames with noise and broken frames mixed in
      frame_no = 0;
      while (frame_bytes < FRAME_BYTE_GOAL) begin
         frame_no++;
         if (frame_no == 20) begin
            // Long receiver hold while bytes keep coming
            holds_asked++;
         end
         if (frame_no == 40) begin
            // Sender pause until every report is out
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (frame_no == 50) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         if (frame_no == 62) begin
            req_idling = 1'b1;
            rsp_idling = 1'b1;
         end
         if (frame_bytes > FRAME_BYTE_GOAL - 120) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         if ($urandom_range(0, 4) == 0) begin
            noise_len = $urandom_range(1, 4);
            repeat (noise_len) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_frame(pick_command(), pick_word(), pick_word(),
                       ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                       pick_tail());
         end
      end

      // Drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request bytes and %0d frame reports.",
               request_count, response_count);
      $display("Reports by status: ok %0d, unknown %0d, checksum %0d, bad tail %0d.",
               ok_count, unknown_count, checksum_count, bad_tail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
